/* rtl/base64_stream_decoder_core_defines.svh */
// Assertion helpers shared by the decoder RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_PAD   = 8'h3D;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CHAR = 2'd1,
    STAT_BAD_LEN  = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // One unit of output work: up to six bytes packed first byte lowest,
  // optionally followed by a byte-less closing result carrying the status.
  typedef struct packed {
    logic [47:0] bytes;
    logic [2:0]  nbytes;
    logic        tail;
    logic        fin;
    status_t     status;
  } job_t;

  // Returns {in_alphabet, sextet}. The pad character maps to zero.
  function automatic logic [6:0] sextet_lookup(input logic [7:0] c, input logic url);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == CHR_PAD) begin
      r = {1'b1, 6'd0};
    end else if (url && c == CHR_MINUS) begin
      r = {1'b1, 6'd62};
    end else if (url && c == CHR_UNDER) begin
      r = {1'b1, 6'd63};
    end else if (!url && c == CHR_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (!url && c == CHR_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // Reorders a 24-bit group so its first byte lands in the lowest bits.
  function automatic logic [23:0] group_bytes(input logic [23:0] g);
    return {g[7:0], g[15:8], g[23:16]};
  endfunction

endpackage

`default_nettype wire

/* rtl/b64d_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            url,
  input  wire logic            accept,
  input  wire logic [7:0]      text_char,
  input  wire logic            end_of_text,
  output logic                 push,
  output b64d_pkg::job_t       job
);

  logic [17:0] partial_r, partial_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [23:0] held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [1:0]  held_pad_r, held_pad_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;
  logic        seen_r, seen_nxt;

  logic        ws;
  logic [6:0]  lk;
  logic [5:0]  s;
  logic        emit0;
  logic [1:0]  pad_mid;
  logic [23:0] g1;
  logic [1:0]  n1;
  logic [23:0] padded;
  logic [2:0]  marks;
  logic        tail;
  b64d_pkg::status_t st;

  always_comb begin
    partial_nxt  = partial_r;
    fill_nxt     = fill_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    held_pad_nxt = held_pad_r;
    pad_nxt      = pad_r;
    err_nxt      = err_r;
    seen_nxt     = seen_r;
    emit0        = 1'b0;
    pad_mid      = pad_r;
    g1           = 24'd0;
    n1           = 2'd0;
    padded       = 24'd0;
    marks        = 3'd0;
    tail         = 1'b0;
    st           = b64d_pkg::STAT_OK;

    ws = (text_char == b64d_pkg::CHR_SPACE) || (text_char == b64d_pkg::CHR_TAB) ||
         (text_char == b64d_pkg::CHR_CR) || (text_char == b64d_pkg::CHR_LF);
    lk = b64d_pkg::sextet_lookup(text_char, url);
    s  = lk[6] ? lk[5:0] : 6'd0;

    if (!ws) begin
      seen_nxt = 1'b1;
      if (!lk[6]) begin
        err_nxt    = 1'b1;
        held_v_nxt = 1'b0;
      end
      // A held group is released in full once another character arrives.
      if (!err_nxt && held_v_nxt) begin
        emit0      = 1'b1;
        held_v_nxt = 1'b0;
      end
      if (text_char == b64d_pkg::CHR_PAD && fill_r >= 2'd2) begin
        pad_mid = pad_r + 2'd1;
      end
      if (fill_r == 2'd3) begin
        held_nxt     = {partial_r, s};
        held_pad_nxt = pad_mid;
        held_v_nxt   = !err_nxt;
        partial_nxt  = 18'd0;
        fill_nxt     = 2'd0;
        pad_nxt      = 2'd0;
      end else begin
        partial_nxt = {partial_r[11:0], s};
        fill_nxt    = fill_r + 2'd1;
        pad_nxt     = pad_mid;
      end
    end

    if (end_of_text) begin
      if (!seen_nxt) begin
        st = b64d_pkg::STAT_EMPTY;
      end else if (!url && fill_nxt != 2'd0) begin
        st = b64d_pkg::STAT_BAD_LEN;
      end else if (err_nxt) begin
        st = b64d_pkg::STAT_BAD_CHAR;
      end

      if (st != b64d_pkg::STAT_OK) begin
        tail = 1'b1;
      end else begin
        if (held_v_nxt) begin
          g1 = held_nxt;
          n1 = 2'd3 - held_pad_nxt;
        end else if (fill_nxt != 2'd0) begin
          // Short final group: missing places count as pad marks.
          case (fill_nxt)
            2'd1: begin
              padded = {partial_nxt[5:0], 18'd0};
              marks  = {1'b0, pad_nxt} + 3'd2;
            end
            2'd2: begin
              padded = {partial_nxt[11:0], 12'd0};
              marks  = {1'b0, pad_nxt} + 3'd2;
            end
            default: begin
              padded = {partial_nxt, 6'd0};
              marks  = {1'b0, pad_nxt} + 3'd1;
            end
          endcase
          if (marks > 3'd2) begin
            marks = 3'd2;
          end
          g1 = padded;
          n1 = 2'd3 - marks[1:0];
        end
        tail = !emit0 && (n1 == 2'd0);
      end

      partial_nxt  = 18'd0;
      fill_nxt     = 2'd0;
      held_nxt     = 24'd0;
      held_v_nxt   = 1'b0;
      held_pad_nxt = 2'd0;
      pad_nxt      = 2'd0;
      err_nxt      = 1'b0;
      seen_nxt     = 1'b0;
    end
  end

  always_comb begin
    job.fin    = end_of_text;
    job.status = st;
    job.tail   = tail;
    if (emit0) begin
      job.bytes  = {b64d_pkg::group_bytes(g1), b64d_pkg::group_bytes(held_r)};
      job.nbytes = 3'd3 + {1'b0, n1};
    end else begin
      job.bytes  = {24'd0, b64d_pkg::group_bytes(g1)};
      job.nbytes = {1'b0, n1};
    end
  end

  assign push = accept && ((job.nbytes != 3'd0) || job.tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= '0;
      fill_r     <= '0;
      held_r     <= '0;
      held_v_r   <= 1'b0;
      held_pad_r <= '0;
      pad_r      <= '0;
      err_r      <= 1'b0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      partial_r  <= partial_nxt;
      fill_r     <= fill_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
      held_pad_r <= held_pad_nxt;
      pad_r      <= pad_nxt;
      err_r      <= err_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b64d_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output b64d_pkg::job_t       head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::job_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire b64d_pkg::job_t  head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic [1:0]           out_status
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic       last_r;
  logic [1:0] status_r;

  logic       load;
  logic       advance;
  logic [3:0] nres;
  logic       last_res;
  logic       is_byte;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign load     = !valid_r || out_ready;
  assign advance  = load && head_valid;
  assign nres     = {1'b0, head_job.nbytes} + {3'd0, head_job.tail};
  assign last_res = ({1'b0, idx_r} == nres - 4'd1);
  assign is_byte  = (idx_r < head_job.nbytes);
  assign cur_byte = head_job.bytes[idx_r*8 +: 8];
  assign cur_last = is_byte ? (head_job.fin && !head_job.tail && last_res) : 1'b1;
  assign pop      = advance && last_res;

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = 3'd0;
    end else if (advance) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r   <= is_byte ? cur_byte : 8'd0;
      bvalid_r <= is_byte;
      last_r   <= cur_last;
      status_r <= is_byte ? b64d_pkg::STAT_OK : head_job.status;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

/* rtl/base64_stream_decoder_core.sv */
// Streaming Base64 decoder, standard or URL-safe alphabet.
// Input stream: one text character per transaction on in_tdata, with in_tlast
// on the final character of the text. Spaces, tabs, CR and LF are dropped.
// Output stream: one decoded byte per transaction on out_tdata; out_tuser[0]
// flags a real byte and out_tuser[2:1] carries the status, which is nonzero
// only on the closing transaction of a text (marked by out_tlast).
// cfg_wr_en/cfg_wr_data select the URL alphabet; write it only while idle.
// A result passes through the job queue and then the output register after
// the character that produces it is accepted. A character is accepted every
// cycle while the job queue has room; output runs at one result per cycle
// while the receiver is ready, and a completed four-character group yields
// up to three results. The classifier writes a job per producing character
// into a QUEUE_DEPTH entry job queue, and in_tready drops only while that
// queue is full: when the receiver stalls, or when closing characters with
// up to six results each arrive faster than one result per cycle drains them.
// Reset clears the decode state, the queue and the output register, and
// selects the standard alphabet. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_core_defines.svh"

module base64_stream_decoder_core #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,   // url_alphabet
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // [7:0] text_char
  input  wire logic       in_tlast,      // end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,     // [7:0] data_byte
  output logic [2:0]      out_tuser,     // [0] byte_valid, [2:1] status
  output logic            out_tlast      // final_result
);

  logic           url_r;
  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  b64d_pkg::job_t push_job;
  b64d_pkg::job_t head_job;
  logic           byte_valid;
  logic [1:0]     status;

  // The alphabet select is a plain register; the user must write it only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r <= 1'b0;
    end else if (cfg_wr_en) begin
      url_r <= cfg_wr_data;
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  // Front end: classifies each character, tracks the open and held groups,
  // and turns every character that causes output into one queued job.
  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .url         (url_r),
    .accept      (accept),
    .text_char   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push),
    .job         (push_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: walks the bytes of the head job into the output register.
  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_byte_valid (byte_valid),
    .out_last       (out_tlast),
    .out_status     (status)
  );

  assign out_tuser = {status, byte_valid};

  // A nonzero status only ever closes a text and never rides on a data byte.
  `B64D_ASSERT_NOW(a_status_on_close, out_tvalid && (out_tuser[2:1] != b64d_pkg::STAT_OK),
    out_tlast && !out_tuser[0], "status reported on a non-closing transaction")

  // A transaction without a byte is always the closing one of its text.
  `B64D_ASSERT_NOW(a_empty_is_last, out_tvalid && !out_tuser[0],
    out_tlast && (out_tdata == 8'd0), "byte-less transaction not closing a text")

  // The queue stops taking characters only when it is actually holding jobs.
  `B64D_ASSERT_NOW(a_stall_needs_jobs, !in_tready, head_valid && out_tvalid,
    "input stalled while the job queue is empty")

endmodule

`default_nettype wire

/* bench/b64d_stream_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the decoder, keeps its own copy of the decode
// state and the alphabet register, and compares every output transaction
// with the oldest predicted result.
module b64d_stream_checker
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic [2:0] out_tuser,
  input  wire logic       out_tlast,
  output int              fail_count,
  output int              pending,
  output int              checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       fin;
    status_t    status;
  } dec_result_t;

  dec_result_t decoded_q[$];

  logic        alpha_url;
  logic [17:0] grp_bits;
  logic [1:0]  grp_fill;
  logic [1:0]  grp_pads;
  logic [23:0] held_bits;
  logic        held_ok;
  logic [1:0]  held_pads;
  logic        bad_seen;
  logic        any_seen;

  dec_result_t step_res[6];
  int          step_n;
  int          mism;
  int          n_checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    mism       = 0;
    n_checked  = 0;
  end

  task automatic clear_decode();
    grp_bits  = '0;
    grp_fill  = '0;
    grp_pads  = '0;
    held_bits = '0;
    held_ok   = 1'b0;
    held_pads = '0;
    bad_seen  = 1'b0;
    any_seen  = 1'b0;
  endtask

  task automatic map_char(input logic [7:0] c, output logic ok, output logic [5:0] v);
    ok = 1'b1;
    v  = 6'd0;
    if (c >= "A" && c <= "Z") v = 6'(c - "A");
    else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
    else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
    else if (c == CHR_PAD) v = 6'd0;
    else if (alpha_url && c == CHR_MINUS) v = 6'd62;
    else if (alpha_url && c == CHR_UNDER) v = 6'd63;
    else if (!alpha_url && c == CHR_PLUS) v = 6'd62;
    else if (!alpha_url && c == CHR_SLASH) v = 6'd63;
    else ok = 1'b0;
  endtask

  task automatic add_result(input logic [7:0] d, input logic v, input status_t st);
    step_res[step_n].data   = d;
    step_res[step_n].valid  = v;
    step_res[step_n].fin    = 1'b0;
    step_res[step_n].status = st;
    step_n++;
  endtask

  // The first byte of a group sits in its top eight bits.
  task automatic add_group(input logic [23:0] g, input int count);
    for (int i = 0; i < count && i < 3; i++)
      add_result(8'((g >> (16 - 8 * i)) & 24'hFF), 1'b1, STAT_OK);
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    logic        ok;
    logic [5:0]  sx;
    logic [23:0] g;
    logic [2:0]  pads;
    status_t     st;
    step_n = 0;
    if (!(c == CHR_SPACE || c == CHR_TAB || c == CHR_CR || c == CHR_LF)) begin
      map_char(c, ok, sx);
      any_seen = 1'b1;
      if (!ok) begin
        bad_seen = 1'b1;
        held_ok  = 1'b0;
        sx       = 6'd0;
      end
      if (!bad_seen && held_ok) begin
        add_group(held_bits, 3);
        held_ok = 1'b0;
      end
      if (c == CHR_PAD && grp_fill >= 2) grp_pads = grp_pads + 2'd1;
      if (grp_fill == 2'd3) begin
        held_bits = {grp_bits, sx};
        held_pads = grp_pads;
        held_ok   = !bad_seen;
        grp_bits  = '0;
        grp_fill  = '0;
        grp_pads  = '0;
      end else begin
        grp_bits = {grp_bits[11:0], sx};
        grp_fill = grp_fill + 2'd1;
      end
    end
    if (last) begin
      if (!any_seen) st = STAT_EMPTY;
      else if (!alpha_url && grp_fill != 0) st = STAT_BAD_LEN;
      else if (bad_seen) st = STAT_BAD_CHAR;
      else st = STAT_OK;
      if (st != STAT_OK) begin
        add_result(8'h00, 1'b0, st);
        step_res[step_n - 1].fin = 1'b1;
      end else begin
        if (held_ok) add_group(held_bits, 3 - held_pads);
        if (grp_fill != 0) begin
          // URL mode closes a short group as if padding had been sent.
          g    = {6'd0, grp_bits};
          pads = {1'b0, grp_pads};
          for (int f = grp_fill; f < 4; f++) begin
            g = g << 6;
            if (f >= 2) pads = pads + 3'd1;
          end
          if (pads > 3'd2) pads = 3'd2;
          add_group(g, 3 - pads);
        end
        if (step_n == 0) add_result(8'h00, 1'b0, STAT_OK);
        step_res[step_n - 1].fin = 1'b1;
      end
      clear_decode();
    end
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endtask

  task automatic report(input string what, input dec_result_t want, input dec_result_t got);
    mism++;
    if (mism <= 10) begin
      $display("[%0t] %s: expected data=%02h valid=%0b last=%0b status=%0d",
               $realtime, what, want.data, want.valid, want.fin, want.status);
      $display("    got data=%02h valid=%0b last=%0b status=%0d",
               got.data, got.valid, got.fin, got.status);
    end
  endtask

  always @(posedge clk) begin : monitor
    dec_result_t got;
    dec_result_t want;
    if (!rst_n) begin
      alpha_url = 1'b0;
      clear_decode();
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.data   = out_tdata;
        got.valid  = out_tuser[0];
        got.fin    = out_tlast;
        got.status = status_t'(out_tuser[2:1]);
        if (decoded_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = decoded_q.pop_front();
          n_checked++;
          if (got.data !== want.data || got.valid !== want.valid ||
              got.fin !== want.fin || got.status !== want.status)
            report("result mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      if (cfg_wr_en) alpha_url = cfg_wr_data;
    end
    pending    <= decoded_q.size();
    fail_count <= mism;
    checked    <= n_checked;
  end

endmodule

/* bench/base64_stream_decoder_core_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the streaming Base64 decoder. All prediction and
// comparison lives in the checker instance that sits beside the decoder.
module base64_stream_decoder_core_tb;
  import b64d_pkg::*;

  // Every input of the decoder starts at a known value.
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic [7:0] in_tdata    = 8'h00;   // [7:0] text_char
  logic       in_tlast    = 1'b0;    // end_of_text
  logic       out_tready  = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;             // [7:0] data_byte
  logic [2:0] out_tuser;             // [0] byte_valid, [2:1] status
  logic       out_tlast;             // final_result

  int fail_count;
  int pending;
  int checked;

  // Percentages of cycles in which the sender holds back or the receiver
  // stalls. Each random phase sets the pair, with two phases per setting.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  int texts_sent = 0;
  int chars_sent = 0;   // non-whitespace characters only

  // Characters of the text that is being assembled.
  logic [7:0] text_buf[$];

  always #5 clk = ~clk;

  base64_stream_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  b64d_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // The receiver stalls at random, one decision per cycle. With a zero
  // percentage it simply stays ready.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic is_space(input logic [7:0] c);
    return c == CHR_SPACE || c == CHR_TAB || c == CHR_CR || c == CHR_LF;
  endfunction

  function automatic logic [7:0] any_space();
    case ($urandom_range(0, 3))
      0:       return CHR_SPACE;
      1:       return CHR_TAB;
      2:       return CHR_CR;
      default: return CHR_LF;
    endcase
  endfunction

  // Character for a sextet in the selected alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return url ? CHR_MINUS : CHR_PLUS;
    return url ? CHR_UNDER : CHR_SLASH;
  endfunction

  // Offers one character and returns at the edge where the transaction
  // completes. A gap before the character is drawn from the sender's idle
  // percentage; in_tvalid only drops when a gap is actually inserted, so
  // back-to-back characters keep it high.
  task automatic send_char(input logic [7:0] c, input logic last);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (!is_space(c)) chars_sent++;
  endtask

  // Sends the assembled text with the end marker on its final character.
  task automatic send_text();
    if (text_buf.size() == 0) text_buf.push_back(any_space());
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    texts_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Appends a character, now and then preceded by whitespace that the
  // decoder has to skip.
  task automatic put_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < 12) text_buf.push_back(any_space());
    text_buf.push_back(c);
  endtask

  // Appends the encoding of nbytes random bytes. Without padding a short
  // final group is left short.
  task automatic put_encoded(input int nbytes, input logic url, input logic pad);
    logic [23:0] g;
    int          nb;
    for (int i = 0; i < nbytes; i += 3) begin
      nb = (nbytes - i >= 3) ? 3 : nbytes - i;
      g  = 24'($urandom());
      if (nb < 3) g[7:0] = 8'h00;
      if (nb < 2) g[15:8] = 8'h00;
      for (int j = 0; j < 4; j++) begin
        if (j <= nb) put_char(sextet_char(g[23 - 6 * j -: 6], url));
        else if (pad) put_char(CHR_PAD);
      end
    end
  endtask

  // One random text. Most texts are well formed so that groups fill, get
  // held and get flushed; the rest corrupt, truncate or replace the text.
  task automatic random_text(input logic url);
    int r;
    int n;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      put_encoded($urandom_range(1, 7), url, url ? logic'($urandom_range(0, 1)) : 1'b1);
      if ($urandom_range(0, 99) < 20) text_buf.push_back(any_space());
    end else if (r < 70) begin
      // One character overwritten by an arbitrary byte.
      put_encoded($urandom_range(1, 7), url, 1'b1);
      pos = $urandom_range(0, text_buf.size() - 1);
      text_buf[pos] = 8'($urandom_range(0, 255));
    end else if (r < 78) begin
      // Final character dropped: a short group in strict mode.
      put_encoded($urandom_range(1, 7), url, 1'b1);
      if (text_buf.size() > 1) void'(text_buf.pop_back());
    end else if (r < 88) begin
      // Noise: arbitrary bytes mixed with alphabet and pad characters.
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 2))
          0:       text_buf.push_back(8'($urandom_range(0, 255)));
          1:       text_buf.push_back(CHR_PAD);
          default: text_buf.push_back(sextet_char(6'($urandom_range(0, 63)),
                                                  logic'($urandom_range(0, 1))));
        endcase
      end
    end else if (r < 94) begin
      // Whitespace only: an empty text.
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) text_buf.push_back(any_space());
    end else begin
      // Padded pieces back to back, so pad characters land mid-text and a
      // held group with pad marks is later sent in full.
      put_encoded($urandom_range(1, 2), url, 1'b1);
      put_encoded($urandom_range(1, 5), url, 1'b1);
    end
    send_text();
  endtask

  // Returns once every predicted result has been delivered. The first edge
  // lets the count pick up the last character; the trailing edges add margin.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write, only ever issued while the decoder is idle.
  task automatic set_alphabet(input logic url);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= url;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_start;
    logic url;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts in the standard alphabet: a full group, one and two
    // pad characters, both special characters, an empty text, a short group
    // closed by trailing whitespace, and bad characters at both byte
    // extremes and mid-text.
    set_alphabet(1'b0);
    send_str("TWFu");
    send_str("TQ==");
    send_str("TWE=");
    send_str("+/+/");
    send_str(" ");
    send_str("\tA\n");
    send_str("A*AA");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    texts_sent += 2;

    // Directed texts in the URL alphabet: a short group that gets padded,
    // and a character that only the standard alphabet accepts.
    wait_idle();
    set_alphabet(1'b1);
    send_str("-_");
    send_str("+");

    // Random phases: the alphabet alternates while the handshake pressure
    // steps through no idling, sender gaps, receiver stalls and both.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      url = ph[0];
      set_alphabet(url);
      case (ph / 2)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 49; end
        default: begin tx_idle_pct = 26; rx_idle_pct = 26; end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < 22) random_text(url);
    end

    wait_idle();
    $display("Run covered %0d texts with %0d encoded characters in both alphabets,",
             texts_sent, chars_sent);
    $display("under four handshake pressure modes; %0d decoded results were compared.",
             checked);
    if (fail_count == 0) begin
      $display("base64_stream_decoder_core verification clean");
    end else begin
      $display("base64_stream_decoder_core verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("base64_stream_decoder_core verification failed");
    $finish;
  end

endmodule
